// ===== rtl/qsed_pkg.sv =====
// Package for the quoted string escape decoder.
// Holds the phase and status codes, character constants and the result record.
// No dependencies.
`default_nettype none

package qsed_pkg;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhStr  = 2'd1,
    PhEsc  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    StData   = 3'd0,
    StEnd    = 3'd1,
    StEof    = 3'd2,
    StNl     = 3'd3,
    StBadEsc = 3'd4
  } status_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/quoted_string_escape_decoder.sv =====
// Top level of the quoted string escape decoder: input register, decode stage,
// result register. Depends on qsed_pkg and qsed_decode.
`default_nettype none

// Channel   Dir  Signals                         Request contents
// s_axis    in   tvalid tready tdata[7:0]        in_byte
// m_axis    out  tvalid tready tdata[7:0]        data_byte
//                tuser[2:0] tlast                status, last
//
// One byte per cycle sustained while m_axis is not stalled; each request is held in the
// input register, and a byte that yields a result is decoded into the result register.
// The rate is set by the single phase register update in the decode stage.
// Reset clears both valid flags and returns the phase to awaiting an opening quote.
// A stall on m_axis holds the result register; the input register still
// takes a request while the result register is empty or draining.

module quoted_string_escape_decoder
  import qsed_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output      logic [2:0] m_axis_tuser,   // [2:0] status
  output      logic       m_axis_tlast
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  status_e    out_status_q;
  logic [7:0] out_data_q;
  logic       out_last_q;
  logic       out_free;
  logic       fire;
  res_t       res;

  // The result register can take a new result when empty or being drained.
  assign out_free      = !out_vld_q || m_axis_tready;
  // Advance the buffered byte through decode when the result slot is free.
  assign fire          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  qsed_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // Result register: load on a firing decode with a result, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= fire && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_status_q <= res.status;
      out_data_q   <= res.data;
      out_last_q   <= res.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_last_marks_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != StData)))
    else $error("tlast disagrees with status");

  a_zero_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == StEnd || m_axis_tuser == StEof ||
      m_axis_tuser == StNl)) |-> (m_axis_tdata == 8'h00))
    else $error("nonzero data on end or error status");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_no_status_beyond : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= StBadEsc))
    else $error("status code out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/qsed_decode.sv =====
// Phase register and per-byte decode logic of the quoted string escape decoder.
// Depends on qsed_pkg.
`default_nettype none

module qsed_decode
  import qsed_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  output res_t            res_o
);

  phase_e phase_q, phase_d;

  always_comb begin
    res_o        = '0;
    res_o.status = StData;
    phase_d      = phase_q;
    case (phase_q)
      PhStr: begin
        phase_d = PhIdle;
        res_o.valid = 1'b1;
        res_o.last  = 1'b1;
        case (byte_i)
          CH_NUL:   res_o.status = StEof;
          CH_LF:    res_o.status = StNl;
          CH_QUOTE: res_o.status = StEnd;
          CH_BSLASH: begin
            res_o.valid = 1'b0;
            res_o.last  = 1'b0;
            phase_d     = PhEsc;
          end
          default: begin
            res_o.last = 1'b0;
            res_o.data = byte_i;
            phase_d    = PhStr;
          end
        endcase
      end
      PhEsc: begin
        res_o.valid = 1'b1;
        phase_d     = PhStr;
        case (byte_i)
          CH_NUL: begin
            res_o.status = StEof;
            res_o.last   = 1'b1;
            phase_d      = PhIdle;
          end
          CH_BSLASH, CH_SLASH, CH_QUOTE: res_o.data = byte_i;
          CH_LC_B: res_o.data = CH_BS;
          CH_LC_F: res_o.data = CH_FF;
          CH_LC_N: res_o.data = CH_LF;
          CH_LC_R: res_o.data = CH_CR;
          CH_LC_T: res_o.data = CH_TAB;
          default: begin
            res_o.status = StBadEsc;
            res_o.data   = byte_i;
            res_o.last   = 1'b1;
            phase_d      = PhIdle;
          end
        endcase
      end
      default: phase_d = PhStr;  // take any byte as the opening quote
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
    end else if (fire_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_quoted_string_escape_decoder.sv =====
// Self-checking testbench for quoted_string_escape_decoder: directed escape and error
// cases, then random strings under varied source gaps and sink stalls.
// Depends on qsed_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb_quoted_string_escape_decoder;
  import qsed_pkg::*;

  // 'u' is not a known escape; it must come back as a bad escape
  localparam logic [7:0] CH_LC_U = 8'h75;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    status_e    status;
    logic [7:0] data;
    logic       last;
  } decoded_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] data_byte
  logic [2:0] m_axis_tuser;   // [2:0] status
  logic       m_axis_tlast;

  // Decoder state as the testbench sees it, and the results it still owes
  phase_e      str_phase;
  decoded_t    pending_results[$];
  int unsigned error_count;
  int unsigned bytes_sent;

  // Idling knobs: percent of cycles the source idles / the sink stalls
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned sink_hold_cycles;

  quoted_string_escape_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Queue one expected result; anything but data ends the string
  function automatic void owe_result(input status_e st, input logic [7:0] value);
    decoded_t r;
    r.status = st;
    r.data   = value;
    r.last   = (st != StData);
    pending_results.push_back(r);
    if (st != StData) str_phase = PhIdle;
  endfunction

  // Advance the decoder state by one source byte and note what it must produce
  function automatic void decode_byte(input logic [7:0] c);
    case (str_phase)
      PhStr: begin
        if (c == CH_NUL) owe_result(StEof, CH_NUL);
        else if (c == CH_LF) owe_result(StNl, CH_NUL);
        else if (c == CH_QUOTE) owe_result(StEnd, CH_NUL);
        else if (c == CH_BSLASH) str_phase = PhEsc;
        else owe_result(StData, c);
      end
      PhEsc: begin
        str_phase = PhStr;
        case (c)
          CH_NUL:                        owe_result(StEof, CH_NUL);
          CH_BSLASH, CH_SLASH, CH_QUOTE: owe_result(StData, c);
          CH_LC_B:                       owe_result(StData, CH_BS);
          CH_LC_F:                       owe_result(StData, CH_FF);
          CH_LC_N:                       owe_result(StData, CH_LF);
          CH_LC_R:                       owe_result(StData, CH_CR);
          CH_LC_T:                       owe_result(StData, CH_TAB);
          default:                       owe_result(StBadEsc, c);
        endcase
      end
      // Between strings any byte counts as the opening quote
      default: str_phase = PhStr;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: one request per call, driven at the falling edge
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    // Idle the source for a random number of cycles first
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    // Hold the request until the decoder takes it
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Drop valid, then wait until every owed result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Let a stray extra result show up before moving on
    repeat (6) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: stall at random, or hold off for a long stretch on request
  // ---------------------------------------------------------------------------

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(negedge clk_i);
        sink_hold_cycles = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t ERROR %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result status=%0d data=%02h last=%b",
                               m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        if (m_axis_tuser !== pending_results[0].status ||
            m_axis_tdata !== pending_results[0].data ||
            m_axis_tlast !== pending_results[0].last) begin
          note_failure($sformatf(
            "result mismatch: exp status=%0d data=%02h last=%b, got status=%0d data=%02h last=%b",
            pending_results[0].status, pending_results[0].data, pending_results[0].last,
            m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] escape_letter(input int unsigned idx);
    case (idx)
      0:       return CH_BSLASH;
      1:       return CH_SLASH;
      2:       return CH_QUOTE;
      3:       return CH_LC_B;
      4:       return CH_LC_F;
      5:       return CH_LC_N;
      6:       return CH_LC_R;
      default: return CH_LC_T;
    endcase
  endfunction

  // Any byte that passes straight through inside a string
  function automatic logic [7:0] plain_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (ch == CH_NUL || ch == CH_LF || ch == CH_QUOTE || ch == CH_BSLASH);
    return ch;
  endfunction

  // One string: mostly well formed, with random content and an occasional bad ending
  task automatic send_random_string();
    int unsigned len;
    int unsigned pick;
    send_byte(($urandom_range(9) < 8) ? CH_QUOTE : 8'($urandom_range(255)));
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_byte(plain_byte());
      end else if (pick < 95) begin
        send_byte(CH_BSLASH);
        send_byte(escape_letter($urandom_range(7)));
      end else begin
        // Noise: may end the string early and start the next one
        send_byte(8'($urandom_range(255)));
      end
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_byte(CH_QUOTE);
    end else if (pick < 80) begin
      send_byte(CH_NUL);
    end else if (pick < 88) begin
      send_byte(CH_LF);
    end else begin
      // Mostly an unknown escape, now and then a valid one
      send_byte(CH_BSLASH);
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero as opener, byte extremes, all known escapes, closing quote
  task automatic test_escapes_directed();
    gap_pct   = 0;
    stall_pct = 0;
    send_byte(CH_NUL);
    send_byte(8'h01);
    send_byte(8'hFF);
    for (int unsigned i = 0; i < 8; i++) begin
      send_byte(CH_BSLASH);
      send_byte(escape_letter(i));
    end
    send_byte(CH_QUOTE);
    wait_drained();
  endtask

  // Each way a string can end badly
  task automatic test_errors_directed();
    gap_pct   = 0;
    stall_pct = 0;
    // End of input inside a string, opened by a newline
    send_byte(CH_LF);
    send_byte(CH_NUL);
    // Raw newline inside a string
    send_byte(8'hFF);
    send_byte(CH_LF);
    // Unicode escape is not decoded
    send_byte(CH_QUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_LC_U);
    // Newline right after a backslash
    send_byte(CH_QUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_LF);
    // End of input right after a backslash
    send_byte(CH_QUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_NUL);
    wait_drained();
  endtask

  task automatic test_random_strings(input int unsigned n, input int unsigned gap,
                                     input int unsigned stall);
    int unsigned stop_at;
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = bytes_sent + n;
    while (bytes_sent < stop_at) send_random_string();
    // The source pauses here until every result has come back
    wait_drained();
  endtask

  // Hold the sink off for a long stretch while the source keeps pushing,
  // so the pipeline fills and the decoder drops s_axis_tready
  task automatic test_backpressure();
    gap_pct          = 0;
    stall_pct        = 0;
    sink_hold_cycles = 150;
    while (sink_hold_cycles != 0) send_random_string();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = 8'h00;
    str_phase        = PhIdle;
    error_count      = 0;
    bytes_sent       = 0;
    gap_pct          = 0;
    stall_pct        = 0;
    sink_hold_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_escapes_directed();
    test_errors_directed();
    test_random_strings(300, 0, 0);
    test_random_strings(300, 61, 0);
    test_random_strings(300, 0, 61);
    test_random_strings(200, 15, 15);
    test_backpressure();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
